// ----- src/irss_pkg.sv -----
`timescale 1ns / 1ps

package irss_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_W        = 12;
    localparam int LEVEL_W         = 12;
    localparam int OFFSET_W        = 12;
    localparam int PHASE_W         = 3;
    localparam int GROUP_W         = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int NUM_OFFSETS     = 4;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_DONE = 1'b1;

    // scan phases
    localparam logic [PHASE_W-1:0] PH_SIDE_DARK      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIDE_DARK_CAP  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SIDE_LIT       = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SIDE_LIT_CAP   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FRONT_DARK     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FRONT_DARK_CAP = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FRONT_LIT      = 3'd6;
    localparam logic [PHASE_W-1:0] PH_FRONT_LIT_CAP  = 3'd7;

    // group done codes
    localparam logic [GROUP_W-1:0] GRP_NONE  = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_SIDE  = 2'd1;
    localparam logic [GROUP_W-1:0] GRP_FRONT = 2'd2;

    // offset register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFS_RIGHT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_LEFT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_FRONT_RIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_FRONT_LEFT  = 2'd3;

    typedef struct packed {
        logic                operation;
        logic                converter_accepted;
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
        logic [SAMPLE_W-1:0] sample_8;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0] scan_phase;
        logic               side_emitters_on;
        logic               front_emitters_on;
        logic               start_conversion;
        logic               capture_lit;
        logic [GROUP_W-1:0] group_done;
        logic [LEVEL_W-1:0] right_level;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] front_right_level;
        logic [LEVEL_W-1:0] front_left_level;
        logic [LEVEL_W-1:0] battery_level;
    } t_out_item;

endpackage

// ----- src/ir_sensor_sync_detect_sequencer.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (irss_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_data (irss_pkg::t_out_item)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while the output is not stalled; two register stages
// the input register feeds one level of add, shift and subtract logic into the
// result register, and the scan state is updated as the result register loads
// synchronous active-low reset clears phase, emitter levels, offsets, averages and levels
// input is taken while a result waits only if the input register is empty

module ir_sensor_sync_detect_sequencer #(
    parameter int SAMPLE_BITS = irss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  irss_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output irss_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [irss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irss_pkg::OFFSET_W-1:0]  i_cfg_data
);

    localparam int AVG_W  = (SAMPLE_BITS < irss_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : irss_pkg::SAMPLE_W;
    localparam int DIFF_W = irss_pkg::LEVEL_W + 2;
    localparam int LW     = irss_pkg::LEVEL_W;

    function automatic logic [AVG_W-1:0] avg2(
        input logic [irss_pkg::SAMPLE_W-1:0] a,
        input logic [irss_pkg::SAMPLE_W-1:0] b
    );
        logic [AVG_W:0] s;
        s = {1'b0, a[AVG_W-1:0]} + {1'b0, b[AVG_W-1:0]};
        return s[AVG_W:1];
    endfunction

    function automatic logic [LW-1:0] clamp_diff(
        input logic [AVG_W-1:0]              on_v,
        input logic [AVG_W-1:0]              off_v,
        input logic [irss_pkg::OFFSET_W-1:0] ofs
    );
        logic signed [DIFF_W-1:0] d;
        d = $signed({{(DIFF_W-AVG_W){1'b0}}, on_v})
          - $signed({{(DIFF_W-AVG_W){1'b0}}, off_v})
          - $signed({{(DIFF_W-irss_pkg::OFFSET_W){1'b0}}, ofs});
        return (d > 0) ? d[LW-1:0] : '0;
    endfunction

    logic                              r_in_valid;
    irss_pkg::t_in_item                r_in_data;
    logic                              r_out_valid;
    irss_pkg::t_out_item               r_out_data;
    logic [irss_pkg::OFFSET_W-1:0]     r_offset [irss_pkg::NUM_OFFSETS];
    logic [irss_pkg::PHASE_W-1:0]      r_phase;
    logic                              r_in_flight;
    logic                              r_side_emit;
    logic                              r_front_emit;
    logic [AVG_W-1:0]                  r_off_avg [irss_pkg::NUM_OFFSETS];
    logic [AVG_W-1:0]                  r_off_batt;
    logic [LW-1:0]                     r_level [5];

    logic [irss_pkg::PHASE_W-1:0]      n_phase;
    logic                              n_in_flight;
    logic                              n_side_emit;
    logic                              n_front_emit;
    logic                              n_store_off;
    logic                              n_store_side;
    logic                              n_store_front;
    logic                              n_start;
    logic                              n_lit;
    logic [irss_pkg::GROUP_W-1:0]      n_group;
    logic [AVG_W-1:0]                  w_avg [irss_pkg::NUM_OFFSETS];
    logic [LW-1:0]                     w_diff [irss_pkg::NUM_OFFSETS];
    logic [LW-1:0]                     n_level [5];
    logic                              w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_avg[0] = avg2(r_in_data.sample_0, r_in_data.sample_2);
    assign w_avg[1] = avg2(r_in_data.sample_1, r_in_data.sample_3);
    assign w_avg[2] = avg2(r_in_data.sample_4, r_in_data.sample_6);
    assign w_avg[3] = avg2(r_in_data.sample_5, r_in_data.sample_7);

    always_comb begin
        for (int k = 0; k < irss_pkg::NUM_OFFSETS; k++) begin
            w_diff[k] = clamp_diff(w_avg[k], r_off_avg[k], r_offset[k]);
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_in_flight   = r_in_flight;
        n_side_emit   = r_side_emit;
        n_front_emit  = r_front_emit;
        n_store_off   = 1'b0;
        n_store_side  = 1'b0;
        n_store_front = 1'b0;
        n_start       = 1'b0;
        n_lit         = 1'b0;
        n_group       = irss_pkg::GRP_NONE;
        if (r_in_data.operation == irss_pkg::OP_TICK) begin
            if (!r_in_flight) begin
                unique case (r_phase)
                    irss_pkg::PH_SIDE_DARK: begin
                        n_side_emit = 1'b0;
                        n_phase     = r_phase + 1'b1;
                    end
                    irss_pkg::PH_SIDE_LIT: begin
                        n_side_emit = 1'b1;
                        n_phase     = r_phase + 1'b1;
                    end
                    irss_pkg::PH_FRONT_DARK: begin
                        n_front_emit = 1'b0;
                        n_phase      = r_phase + 1'b1;
                    end
                    irss_pkg::PH_FRONT_LIT: begin
                        n_front_emit = 1'b1;
                        n_phase      = r_phase + 1'b1;
                    end
                    default: begin
                        n_start = 1'b1;
                        n_lit   = (r_phase == irss_pkg::PH_SIDE_LIT_CAP)
                               || (r_phase == irss_pkg::PH_FRONT_LIT_CAP);
                        if (r_in_data.converter_accepted) begin
                            n_in_flight = 1'b1;
                        end
                    end
                endcase
            end
        end else begin
            unique case (r_phase) inside
                irss_pkg::PH_SIDE_DARK_CAP, irss_pkg::PH_FRONT_DARK_CAP: begin
                    n_store_off = 1'b1;
                end
                irss_pkg::PH_SIDE_LIT_CAP: begin
                    n_store_side = 1'b1;
                    n_side_emit  = 1'b0;
                    n_group      = irss_pkg::GRP_SIDE;
                end
                irss_pkg::PH_FRONT_LIT_CAP: begin
                    n_store_front = 1'b1;
                    n_front_emit  = 1'b0;
                    n_group       = irss_pkg::GRP_FRONT;
                end
                default: begin
                end
            endcase
            n_in_flight = 1'b0;
            n_phase     = r_phase + 1'b1;
        end
    end

    always_comb begin
        n_level[0] = n_store_side  ? w_diff[0] : r_level[0];
        n_level[1] = n_store_side  ? w_diff[1] : r_level[1];
        n_level[2] = n_store_front ? w_diff[2] : r_level[2];
        n_level[3] = n_store_front ? w_diff[3] : r_level[3];
        n_level[4] = n_store_front ? LW'(r_off_batt) : r_level[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= irss_pkg::PH_SIDE_DARK;
            r_in_flight  <= 1'b0;
            r_side_emit  <= 1'b0;
            r_front_emit <= 1'b0;
            r_off_batt   <= '0;
            for (int k = 0; k < irss_pkg::NUM_OFFSETS; k++) begin
                r_offset[k]  <= '0;
                r_off_avg[k] <= '0;
            end
            for (int k = 0; k < 5; k++) begin
                r_level[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_offset[i_cfg_index] <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase      <= n_phase;
                r_in_flight  <= n_in_flight;
                r_side_emit  <= n_side_emit;
                r_front_emit <= n_front_emit;
                if (n_store_off) begin
                    for (int k = 0; k < irss_pkg::NUM_OFFSETS; k++) begin
                        r_off_avg[k] <= w_avg[k];
                    end
                    r_off_batt <= r_in_data.sample_8[AVG_W-1:0];
                end
                for (int k = 0; k < 5; k++) begin
                    r_level[k] <= n_level[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (w_advance) begin
            r_out_data.scan_phase        <= n_phase;
            r_out_data.side_emitters_on  <= n_side_emit;
            r_out_data.front_emitters_on <= n_front_emit;
            r_out_data.start_conversion  <= n_start;
            r_out_data.capture_lit       <= n_lit;
            r_out_data.group_done        <= n_group;
            r_out_data.right_level       <= n_level[0];
            r_out_data.left_level        <= n_level[1];
            r_out_data.front_right_level <= n_level[2];
            r_out_data.front_left_level  <= n_level[3];
            r_out_data.battery_level     <= n_level[4];
        end
    end

    a_flight_from_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_flight) |-> r_phase[0])
        else $error("conversion went in flight outside a capture phase");

    a_start_at_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.start_conversion) |-> o_out_data.scan_phase[0])
        else $error("conversion requested outside a capture phase");

    a_side_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.group_done == irss_pkg::GRP_SIDE)
        |-> (o_out_data.scan_phase == irss_pkg::PH_FRONT_DARK
             && !o_out_data.side_emitters_on))
        else $error("side levels reported in the wrong phase");

    a_front_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.group_done == irss_pkg::GRP_FRONT)
        |-> (o_out_data.scan_phase == irss_pkg::PH_SIDE_DARK
             && !o_out_data.front_emitters_on))
        else $error("front levels reported in the wrong phase");

    a_flight_no_tick_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_flight && r_in_data.operation == irss_pkg::OP_TICK)
        |=> ($stable(r_phase) && r_in_flight))
        else $error("tick moved the scan while a conversion was in flight");

endmodule

// ----- verif/irss_scan_checker.sv -----
`timescale 1ns / 1ps

module irss_scan_checker
    import irss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OFFSET_W-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    t_out_item            expected_scans[$];
    int                   mismatch_count;

    logic [PHASE_W-1:0]   scan_phase_q;
    logic                 conv_busy;
    logic                 side_on;
    logic                 front_on;
    logic [SAMPLE_W-1:0]  dark_right, dark_left, dark_front_right, dark_front_left;
    logic [SAMPLE_W-1:0]  dark_battery;
    logic [LEVEL_W-1:0]   right_lvl, left_lvl, front_right_lvl, front_left_lvl, battery_lvl;
    logic [OFFSET_W-1:0]  offsets [NUM_OFFSETS];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatch_count = 0;
    end

    function automatic logic [SAMPLE_W-1:0] mean_of(logic [SAMPLE_W-1:0] a,
                                                    logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SAMPLE_W:1];
    endfunction

    function automatic logic [LEVEL_W-1:0] lift_over(logic [SAMPLE_W-1:0] lit,
                                                     logic [SAMPLE_W-1:0] dark,
                                                     logic [OFFSET_W-1:0] ofs);
        int d;
        d = int'(lit) - int'(dark) - int'(ofs);
        return (d > 0) ? d[LEVEL_W-1:0] : '0;
    endfunction

    function automatic string show_scan(t_out_item r);
        return {$sformatf("ph=%0d side=%0b front=%0b start=%0b lit=%0b grp=%0d ",
                          r.scan_phase, r.side_emitters_on, r.front_emitters_on,
                          r.start_conversion, r.capture_lit, r.group_done),
                $sformatf("r=%0d l=%0d fr=%0d fl=%0d bat=%0d",
                          r.right_level, r.left_level, r.front_right_level,
                          r.front_left_level, r.battery_level)};
    endfunction

    task automatic clear_scan_state();
        scan_phase_q = PH_SIDE_DARK;
        conv_busy    = 1'b0;
        side_on      = 1'b0;
        front_on     = 1'b0;
        dark_right   = '0;
        dark_left    = '0;
        dark_front_right = '0;
        dark_front_left  = '0;
        dark_battery = '0;
        right_lvl    = '0;
        left_lvl     = '0;
        front_right_lvl = '0;
        front_left_lvl  = '0;
        battery_lvl  = '0;
        for (int i = 0; i < NUM_OFFSETS; i++) offsets[i] = '0;
    endtask

    task automatic advance_scan(input t_in_item it, output t_out_item res);
        logic [PHASE_W-1:0] ph;
        logic               req;
        logic               lit;
        logic [GROUP_W-1:0] grp;
        ph  = scan_phase_q;
        req = 1'b0;
        lit = 1'b0;
        grp = GRP_NONE;
        if (it.operation == OP_TICK) begin
            if (!conv_busy) begin
                case (ph)
                    PH_SIDE_DARK:  side_on  = 1'b0;
                    PH_SIDE_LIT:   side_on  = 1'b1;
                    PH_FRONT_DARK: front_on = 1'b0;
                    PH_FRONT_LIT:  front_on = 1'b1;
                    default: begin
                        req = 1'b1;
                        lit = (ph == PH_SIDE_LIT_CAP) || (ph == PH_FRONT_LIT_CAP);
                    end
                endcase
                if (req) begin
                    if (it.converter_accepted) conv_busy = 1'b1;
                end else begin
                    scan_phase_q = ph + 1'b1;
                end
            end
        end else begin
            case (ph)
                PH_SIDE_DARK_CAP, PH_FRONT_DARK_CAP: begin
                    dark_right       = mean_of(it.sample_0, it.sample_2);
                    dark_left        = mean_of(it.sample_1, it.sample_3);
                    dark_front_right = mean_of(it.sample_4, it.sample_6);
                    dark_front_left  = mean_of(it.sample_5, it.sample_7);
                    dark_battery     = it.sample_8;
                end
                PH_SIDE_LIT_CAP: begin
                    right_lvl = lift_over(mean_of(it.sample_0, it.sample_2), dark_right,
                                          offsets[REG_OFS_RIGHT]);
                    left_lvl  = lift_over(mean_of(it.sample_1, it.sample_3), dark_left,
                                          offsets[REG_OFS_LEFT]);
                    side_on   = 1'b0;
                    grp       = GRP_SIDE;
                end
                PH_FRONT_LIT_CAP: begin
                    front_right_lvl = lift_over(mean_of(it.sample_4, it.sample_6),
                                                dark_front_right,
                                                offsets[REG_OFS_FRONT_RIGHT]);
                    front_left_lvl  = lift_over(mean_of(it.sample_5, it.sample_7),
                                                dark_front_left,
                                                offsets[REG_OFS_FRONT_LEFT]);
                    battery_lvl     = dark_battery;
                    front_on        = 1'b0;
                    grp             = GRP_FRONT;
                end
                default: ;
            endcase
            conv_busy    = 1'b0;
            scan_phase_q = ph + 1'b1;
        end
        res.scan_phase        = scan_phase_q;
        res.side_emitters_on  = side_on;
        res.front_emitters_on = front_on;
        res.start_conversion  = req;
        res.capture_lit       = lit;
        res.group_done        = grp;
        res.right_level       = right_lvl;
        res.left_level        = left_lvl;
        res.front_right_level = front_right_lvl;
        res.front_left_level  = front_left_lvl;
        res.battery_level     = battery_lvl;
    endtask

    task automatic check_scan(input t_out_item got);
        t_out_item want;
        if (expected_scans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: no transaction expected, got %s", show_scan(got));
        end else begin
            want = expected_scans.pop_front();
            if (got.scan_phase != want.scan_phase
                    || got.side_emitters_on != want.side_emitters_on
                    || got.front_emitters_on != want.front_emitters_on
                    || got.start_conversion != want.start_conversion
                    || got.capture_lit != want.capture_lit
                    || got.group_done != want.group_done
                    || got.right_level != want.right_level
                    || got.left_level != want.left_level
                    || got.front_right_level != want.front_right_level
                    || got.front_left_level != want.front_left_level
                    || got.battery_level != want.battery_level) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch: expected %s", show_scan(want));
                    $display("          actual   %s", show_scan(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_scan_state();
            expected_scans.delete();
        end else begin
            if (i_cfg_we) offsets[i_cfg_index] = i_cfg_data;
            if (i_out_valid && i_out_ready) check_scan(i_out_data);
            if (i_in_valid && i_in_ready) begin
                advance_scan(i_in_data, want);
                expected_scans.push_back(want);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_scans.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import irss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 260;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_OFS_RIGHT;
    logic [OFFSET_W-1:0]  cfg_data  = '0;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   ready_mode  = 0;

    // stimulus-side view of where the scan stands
    logic [PHASE_W-1:0]   scan_at     = PH_SIDE_DARK;
    logic                 conv_open   = 1'b0;
    int                   useful_items = 0;

    ir_sensor_sync_detect_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    irss_scan_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (cycle_count % 300 == 0) ready_mode <= int'($urandom_range(0, 3));
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((cycle_count % 9) < 4);
        endcase
    end

    function automatic logic is_capture(logic [PHASE_W-1:0] ph);
        return ph == PH_SIDE_DARK_CAP || ph == PH_SIDE_LIT_CAP
            || ph == PH_FRONT_DARK_CAP || ph == PH_FRONT_LIT_CAP;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic t_in_item make_item(logic op, logic acc,
                                           logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        t_in_item it;
        it.operation          = op;
        it.converter_accepted = acc;
        it.sample_0 = a;
        it.sample_1 = a;
        it.sample_2 = b;
        it.sample_3 = b;
        it.sample_4 = a;
        it.sample_5 = a;
        it.sample_6 = b;
        it.sample_7 = b;
        it.sample_8 = a;
        return it;
    endfunction

    // mostly well-formed scan traffic, with some noise mixed in
    function automatic t_in_item next_scan_item();
        t_in_item it;
        int       roll;
        it.sample_0 = pick_sample();
        it.sample_1 = pick_sample();
        it.sample_2 = pick_sample();
        it.sample_3 = pick_sample();
        it.sample_4 = pick_sample();
        it.sample_5 = pick_sample();
        it.sample_6 = pick_sample();
        it.sample_7 = pick_sample();
        it.sample_8 = pick_sample();
        it.converter_accepted = 1'($urandom_range(0, 1));
        roll = int'($urandom_range(0, 99));
        if (roll < 10) begin
            it.operation = 1'($urandom_range(0, 1));
        end else if (conv_open) begin
            it.operation = (roll < 25) ? OP_TICK : OP_DONE;
        end else begin
            it.operation = OP_TICK;
            if (is_capture(scan_at)) it.converter_accepted = ($urandom_range(0, 3) != 0);
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.operation == OP_TICK) begin
            if (!conv_open) begin
                useful_items++;
                if (!is_capture(scan_at)) scan_at = scan_at + 1'b1;
                else if (it.converter_accepted) conv_open = 1'b1;
            end
        end else begin
            useful_items++;
            conv_open = 1'b0;
            scan_at   = scan_at + 1'b1;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic load_offsets(input logic [OFFSET_W-1:0] r, input logic [OFFSET_W-1:0] l,
                                input logic [OFFSET_W-1:0] fr, input logic [OFFSET_W-1:0] fl);
        logic [CFG_IDX_W-1:0] regs [NUM_OFFSETS];
        logic [OFFSET_W-1:0]  vals [NUM_OFFSETS];
        int                   i;
        regs = '{REG_OFS_RIGHT, REG_OFS_LEFT, REG_OFS_FRONT_RIGHT, REG_OFS_FRONT_LEFT};
        vals = '{r, l, fr, fl};
        for (i = 0; i < NUM_OFFSETS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_scans(input int n);
        int target;
        int burst;
        int gap;
        target = useful_items + n;
        while (useful_items < target) begin
            burst = int'($urandom_range(1, 24));
            repeat (burst) send_item(next_scan_item());
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_offsets('0, '0, '0, '0);

        send_item(make_item(OP_TICK, 1'b0, 12'h000, 12'h000));
        // capture refused, then accepted, then a tick while busy
        send_item(make_item(OP_TICK, 1'b0, 12'h000, 12'h000));
        send_item(make_item(OP_TICK, 1'b1, 12'h000, 12'h000));
        send_item(make_item(OP_TICK, 1'b1, 12'hfff, 12'hfff));
        send_item(make_item(OP_DONE, 1'b0, 12'h000, 12'h000));
        send_item(make_item(OP_TICK, 1'b1, 12'h000, 12'h000));
        send_item(make_item(OP_TICK, 1'b1, 12'h000, 12'h000));
        send_item(make_item(OP_DONE, 1'b1, 12'hfff, 12'hfff));
        // completion on a set phase with nothing in flight
        send_item(make_item(OP_DONE, 1'b0, 12'h123, 12'h456));
        send_item(make_item(OP_TICK, 1'b1, 12'h000, 12'h000));
        send_item(make_item(OP_DONE, 1'b0, 12'hfff, 12'hffe));
        send_item(make_item(OP_TICK, 1'b0, 12'h000, 12'h000));
        send_item(make_item(OP_TICK, 1'b1, 12'h000, 12'h000));
        // lit below dark clamps to zero
        send_item(make_item(OP_DONE, 1'b1, 12'h000, 12'h001));
        send_item(make_item(OP_DONE, 1'b1, 12'haaa, 12'h555));
        send_item(make_item(OP_DONE, 1'b0, 12'h555, 12'haaa));
        send_item(make_item(OP_TICK, 1'b0, 12'h000, 12'h000));
        send_item(make_item(OP_DONE, 1'b1, 12'hfff, 12'hfff));
        drain();

        for (int k = 0; k < 6; k++) begin
            case (k)
                0: load_offsets('1, '1, '1, '1);
                1: load_offsets(OFFSET_W'($urandom_range(0, 4095)),
                                OFFSET_W'($urandom_range(0, 4095)),
                                OFFSET_W'($urandom_range(0, 4095)),
                                OFFSET_W'($urandom_range(0, 4095)));
                2: load_offsets(OFFSET_W'($urandom_range(0, 63)),
                                OFFSET_W'($urandom_range(0, 63)),
                                OFFSET_W'($urandom_range(0, 63)),
                                OFFSET_W'($urandom_range(0, 63)));
                3: load_offsets('0, '1, '1, '0);
                4: load_offsets(OFFSET_W'($urandom_range(0, 511)),
                                OFFSET_W'($urandom_range(0, 4095)),
                                OFFSET_W'($urandom_range(0, 511)),
                                OFFSET_W'($urandom_range(0, 4095)));
                default: load_offsets('0, '0, '0, '0);
            endcase
            run_scans(PHASE_ITEMS);
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
